/* sv/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  // Default number of entry cells in the sorted array.
  localparam int DepthDef = 16;

  // Field widths fixed by the interface.
  localparam int ReqW   = 2;
  localparam int PidW   = 8;
  localparam int PrioW  = 8;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqW-1:0] REQ_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the accepted request beat
    logic exec;      // apply the request and load the result register
  } cmd_t;

endpackage

/* sv/spq_ctrl.sv */
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec;

  // A request is taken only when no other request is in flight.
  assign in_ready = (state_r == S_IDLE);

  // The request executes once the result register is free or being drained.
  assign exec = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign cmd.load_req = in_valid && in_ready;
  assign cmd.exec     = exec;
  assign out_valid    = out_valid_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result register fills on execute and empties when its beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/spq_dpath.sv */
`timescale 1ns / 1ps

module spq_dpath #(
  parameter int QUEUE_DEPTH = spq_pkg::DepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::cmd_t                cmd,
  input  logic [spq_pkg::ReqW-1:0]     in_req_type,
  input  logic [spq_pkg::PidW-1:0]     in_process_id,
  input  logic [spq_pkg::PrioW-1:0]    in_priority_req,
  output logic [spq_pkg::StatW-1:0]    out_status,
  output logic [spq_pkg::PidW-1:0]     out_process_id,
  output logic [spq_pkg::PrioW-1:0]    out_priority,
  output logic                         out_is_empty,
  output logic [spq_pkg::CountW-1:0]   out_entry_count_out
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  // Captured request.
  logic [ReqW-1:0]  req_r;
  logic [PidW-1:0]  pid_r;
  logic [PrioW-1:0] prio_r;

  // Sorted cell array, cell 0 is served next.
  logic [PidW-1:0]  cell_pid_r   [QUEUE_DEPTH];
  logic [PrioW-1:0] cell_prio_r  [QUEUE_DEPTH];
  logic [PidW-1:0]  cell_pid_nxt [QUEUE_DEPTH];
  logic [PrioW-1:0] cell_prio_nxt[QUEUE_DEPTH];
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  // Result register.
  logic [StatW-1:0]  stat_r, stat_nxt;
  logic [PidW-1:0]   rpid_r, rpid_nxt;
  logic [PrioW-1:0]  rprio_r, rprio_nxt;
  logic              empty_r;
  logic [CountW-1:0] cnt_out_r;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] open;
  logic full, empty, do_ins, do_rem;

  assign full   = (cnt_r == CntW'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_ins = (req_r == REQ_INSERT) && !full;
  assign do_rem = (req_r == REQ_REMOVE) && !empty;

  // Every cell compares its priority against the new one in parallel.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid[i] = (CntW'(i) < cnt_r);
      gt[i]    = valid[i] && (cell_prio_r[i] > prio_r);
      open[i]  = gt[i] || !valid[i];
    end
  end

  // Cell update: shift toward the tail on insert, toward the head on remove.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_pid_nxt[i]  = cell_pid_r[i];
      cell_prio_nxt[i] = cell_prio_r[i];
      if (do_ins) begin
        if (i > 0 && gt[i-1]) begin
          cell_pid_nxt[i]  = cell_pid_r[i-1];
          cell_prio_nxt[i] = cell_prio_r[i-1];
        end else if (open[i] && !(i > 0 && open[i-1])) begin
          cell_pid_nxt[i]  = pid_r;
          cell_prio_nxt[i] = prio_r;
        end
      end else if (do_rem && i < QUEUE_DEPTH - 1) begin
        cell_pid_nxt[i]  = cell_pid_r[i+1];
        cell_prio_nxt[i] = cell_prio_r[i+1];
      end
    end
  end

  // Count and result fields.
  always_comb begin
    cnt_nxt   = cnt_r;
    stat_nxt  = STAT_OK;
    rpid_nxt  = '0;
    rprio_nxt = '0;
    if (req_r == REQ_INSERT) begin
      if (full) begin
        stat_nxt = STAT_FULL;
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
      end
    end else if (req_r == REQ_REMOVE) begin
      if (empty) begin
        stat_nxt = STAT_EMPTY;
      end else begin
        cnt_nxt   = cnt_r - CntW'(1);
        rpid_nxt  = cell_pid_r[0];
        rprio_nxt = cell_prio_r[0];
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= in_req_type;
      pid_r  <= in_process_id;
      prio_r <= in_priority_req;
    end
  end

  // Cell array and result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        cell_pid_r[i]  <= cell_pid_nxt[i];
        cell_prio_r[i] <= cell_prio_nxt[i];
      end
      stat_r    <= stat_nxt;
      rpid_r    <= rpid_nxt;
      rprio_r   <= rprio_nxt;
      empty_r   <= (cnt_nxt == '0);
      cnt_out_r <= CountW'(cnt_nxt);
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_status          = stat_r;
  assign out_process_id      = rpid_r;
  assign out_priority        = rprio_r;
  assign out_is_empty        = empty_r;
  assign out_entry_count_out = cnt_out_r;

endmodule

/* sv/sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Channel  Handshake             Beat contents
// in       in_valid / in_ready   in_req_type, in_process_id, in_priority_req
// out      out_valid / out_ready out_status, out_process_id, out_priority,
//                                out_is_empty, out_entry_count_out
//
// Each request is first captured, then applied in the execute state, in which
// every cell of the sorted array compares and shifts in parallel.
// The result register holds one beat; the next request is captured while it
// waits, and executes as soon as that beat is taken.
// Reset (synchronous, active low) empties the queue; cell contents stay as is.

module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::DepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::ReqW-1:0]     in_req_type,
  input  logic [spq_pkg::PidW-1:0]     in_process_id,
  input  logic [spq_pkg::PrioW-1:0]    in_priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spq_pkg::StatW-1:0]    out_status,
  output logic [spq_pkg::PidW-1:0]     out_process_id,
  output logic [spq_pkg::PrioW-1:0]    out_priority,
  output logic                         out_is_empty,
  output logic [spq_pkg::CountW-1:0]   out_entry_count_out
);
  import spq_pkg::*;

  cmd_t cmd;

  // Sequencing of capture, execute and result delivery.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Sorted cell array and result register.
  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_req_type         (in_req_type),
    .in_process_id       (in_process_id),
    .in_priority_req     (in_priority_req),
    .out_status          (out_status),
    .out_process_id      (out_process_id),
    .out_priority        (out_priority),
    .out_is_empty        (out_is_empty),
    .out_entry_count_out (out_entry_count_out)
  );

`ifndef SYNTH
  // An execute always leaves a result beat waiting.
  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute did not produce a result beat");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is pending");

  // A dropped insert reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |->
      (out_entry_count_out == CountW'(QUEUE_DEPTH)))
    else $error("full status with a count below depth");

  // A remove from an empty queue returns nothing and reports empty.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |->
      (out_is_empty && out_process_id == '0 && out_priority == '0))
    else $error("empty status with a nonzero result");
`endif

endmodule
